@@ rtl/mas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg
// Shared types and constants for the matrix add / subtract / multiply engine.
// ----------------------------------------------------------------------------
package mas_pkg;

	localparam int MAX_DIM_DEF       = 8;
	localparam int ELEMENT_WIDTH_DEF = 32;

	localparam int IDX_W  = 3;
	localparam int DIM_W  = 4;
	localparam int IN_W   = 32;
	localparam int RES_W  = 64;
	localparam int CFG_W  = 4;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ADD  = 2'd1;
	localparam logic [1:0] CMD_SUB  = 2'd2;
	localparam logic [1:0] CMD_MUL  = 2'd3;

	// configuration register indexes
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	typedef struct packed {
		logic [1:0]              command;
		logic [IDX_W-1:0]        row_index;
		logic [IDX_W-1:0]        column_index;
		logic signed [IN_W-1:0]  a_value;
		logic signed [IN_W-1:0]  b_value;
	} mas_in_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic [IDX_W-1:0]        result_row;
		logic [IDX_W-1:0]        result_column;
		logic                    is_last;
		logic                    status;
	} mas_out_t;

	// one step issued by the controller
	typedef struct packed {
		logic             load;
		logic             issue;
		logic             err;
		logic [1:0]       op;
		logic [IDX_W-1:0] a_row;
		logic [IDX_W-1:0] a_col;
		logic [IDX_W-1:0] b_row;
		logic [IDX_W-1:0] b_col;
		logic             first;
		logic             fin;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} mas_cmd_t;

	typedef struct packed {
		logic done;
		logic strobe;
	} mas_status_t;

endpackage

@@ rtl/matrix_add_sub_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply
// Integer matrix engine: element pair loads, element-wise sum and difference
// and square matrix product over two stored matrices.
// ----------------------------------------------------------------------------
// a load takes the cycle of its transfer; busy stays low
// add / subtract: steps pass store read, term register and result register;
//   one result per cycle (two-port element stores, one read each)
// multiply: each result sums n products in the single shared multiply-accumulate;
//   a refused product gives one result
// busy falls the cycle after the last result; results cannot be stalled
// reset: row and column counts go to 8, element stores hold nothing defined
module matrix_add_sub_multiply #(
	parameter int MAX_DIM       = mas_pkg::MAX_DIM_DEF,
	parameter int ELEMENT_WIDTH = mas_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  mas_pkg::mas_in_t          item,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [mas_pkg::CFG_W-1:0] cfg_data,
	output logic                      result_valid,
	output mas_pkg::mas_out_t         result
);

	mas_pkg::mas_cmd_t    cmd;
	mas_pkg::mas_status_t stat;

	mas_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.command   (item.command),
		.busy      (busy),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	mas_dp #(.MAX_DIM(MAX_DIM), .ELEMENT_WIDTH(ELEMENT_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a run");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command == mas_pkg::CMD_LOAD |=> !busy)
		else $error("load raised busy");

	a_compute_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.command != mas_pkg::CMD_LOAD |=> busy)
		else $error("compute transfer did not start a run");

endmodule

@@ rtl/mas_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mas_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/mas_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_ctrl
// Controller: configuration registers, run state machine and index counters.
// ----------------------------------------------------------------------------
module mas_ctrl #(
	parameter int MAX_DIM = mas_pkg::MAX_DIM_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                command,
	output logic                      busy,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [mas_pkg::CFG_W-1:0] cfg_data,
	output mas_pkg::mas_cmd_t         cmd,
	input  mas_pkg::mas_status_t      stat
);

	localparam int IdxW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_ERR   = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [mas_pkg::DIM_W-1:0]   row_count_q;
	logic [mas_pkg::DIM_W-1:0]   column_count_q;
	logic [1:0]                  op_q;
	logic [IdxW-1:0]             i_q, j_q, k_q;
	logic [IdxW-1:0]             row_last, col_last;
	logic                        mul, k_end, j_end, i_end;

	// highest index in use for a dimension register; zero acts as one
	function automatic logic [IdxW-1:0] dim_last(input logic [mas_pkg::DIM_W-1:0] r);
		logic [IdxW-1:0] res;
		if (r == '0) begin
			res = '0;
		end else if (r > mas_pkg::DIM_W'(MAX_DIM)) begin
			res = IdxW'(MAX_DIM - 1);
		end else begin
			res = IdxW'(r - 1'b1);
		end
		return res;
	endfunction

	assign row_last = dim_last(row_count_q);
	assign col_last = dim_last(column_count_q);
	assign mul      = (op_q == mas_pkg::CMD_MUL);
	assign k_end    = !mul || (k_q == row_last);
	assign j_end    = (j_q == col_last);
	assign i_end    = (i_q == row_last);
	assign busy     = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= mas_pkg::DIM_RESET;
			column_count_q <= mas_pkg::DIM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mas_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data;
				mas_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= mas_pkg::CMD_LOAD;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && command != mas_pkg::CMD_LOAD) begin
						op_q <= command;
						i_q  <= '0;
						j_q  <= '0;
						k_q  <= '0;
						if (command == mas_pkg::CMD_MUL && row_last != col_last) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (!k_end) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q <= j_q + 1'b1;
						end else begin
							j_q <= '0;
							if (!i_end) begin
								i_q <= i_q + 1'b1;
							end else begin
								state_q <= S_DRAIN;
							end
						end
					end
				end
				S_ERR: begin
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (stat.done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.op   = op_q;
		cmd.load = (state_q == S_IDLE) && start && (command == mas_pkg::CMD_LOAD);
		if (state_q == S_RUN) begin
			cmd.issue = 1'b1;
			cmd.a_row = mas_pkg::IDX_W'(i_q);
			cmd.a_col = mas_pkg::IDX_W'(mul ? k_q : j_q);
			cmd.b_row = mas_pkg::IDX_W'(mul ? k_q : i_q);
			cmd.b_col = mas_pkg::IDX_W'(j_q);
			cmd.first = !mul || (k_q == '0);
			cmd.fin   = k_end;
			cmd.row   = mas_pkg::IDX_W'(i_q);
			cmd.col   = mas_pkg::IDX_W'(j_q);
			cmd.last  = i_end && j_end;
		end else if (state_q == S_ERR) begin
			cmd.issue = 1'b1;
			cmd.err   = 1'b1;
			cmd.first = 1'b1;
			cmd.fin   = 1'b1;
			cmd.last  = 1'b1;
		end
	end

	// the drain state only ends on the final result of the run
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == S_DRAIN)
		else $error("last result outside drain");

	a_no_issue_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cmd.issue)
		else $error("step issued while idle");

	a_err_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ERR |=> state_q == S_DRAIN)
		else $error("refusal not followed by drain");

endmodule

@@ rtl/mas_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_dp
// Datapath: element stores, read stage, add / subtract / multiply stage and
// accumulator with the result register.
// ----------------------------------------------------------------------------
module mas_dp #(
	parameter int MAX_DIM       = mas_pkg::MAX_DIM_DEF,
	parameter int ELEMENT_WIDTH = mas_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mas_pkg::mas_in_t     item,
	input  mas_pkg::mas_cmd_t    cmd,
	output mas_pkg::mas_status_t stat,
	output logic                 result_valid,
	output mas_pkg::mas_out_t    result
);

	localparam int SW    = (ELEMENT_WIDTH < 32) ? ELEMENT_WIDTH : 32;
	localparam int Depth = MAX_DIM * MAX_DIM;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	logic             wr_en;
	logic [AddrW-1:0] wr_addr, a_addr, b_addr;
	logic [SW-1:0]    a_rd, b_rd;

	mas_pkg::mas_cmd_t          tag_s1, tag_s2;
	logic signed [2*SW-1:0]     prod;
	logic signed [63:0]         a_ext, b_ext, term;
	logic signed [63:0]         term_s2;
	logic signed [63:0]         acc_q, sum;
	logic                       valid_s1, valid_s2;
	logic                       result_valid_q;
	mas_pkg::mas_out_t          result_q;

	// loads outside the stores are dropped
	assign wr_en   = cmd.load && (int'(item.row_index) < MAX_DIM)
	                          && (int'(item.column_index) < MAX_DIM);
	assign wr_addr = AddrW'(int'(item.row_index) * MAX_DIM + int'(item.column_index));
	assign a_addr  = AddrW'(int'(cmd.a_row) * MAX_DIM + int'(cmd.a_col));
	assign b_addr  = AddrW'(int'(cmd.b_row) * MAX_DIM + int'(cmd.b_col));

	mas_ram #(.WIDTH(SW), .DEPTH(Depth), .ADDR_W(AddrW)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item.a_value[SW-1:0]),
		.re    (cmd.issue && !cmd.err),
		.raddr (a_addr),
		.rdata (a_rd)
	);

	mas_ram #(.WIDTH(SW), .DEPTH(Depth), .ADDR_W(AddrW)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item.b_value[SW-1:0]),
		.re    (cmd.issue && !cmd.err),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= cmd.issue;
			valid_s2       <= valid_s1;
			result_valid_q <= valid_s2 && tag_s2.fin;
		end
	end

	assign a_ext = 64'($signed(a_rd));
	assign b_ext = 64'($signed(b_rd));
	assign prod  = $signed(a_rd) * $signed(b_rd);

	always_comb begin
		case (tag_s1.op)
			mas_pkg::CMD_ADD: term = a_ext + b_ext;
			mas_pkg::CMD_SUB: term = a_ext - b_ext;
			default:          term = 64'(prod);
		endcase
	end

	assign sum = tag_s2.first ? term_s2 : acc_q + term_s2;

	always_ff @(posedge clk) begin
		tag_s1  <= cmd;
		tag_s2  <= tag_s1;
		term_s2 <= term;
		if (valid_s2) begin
			acc_q <= sum;
			if (tag_s2.fin) begin
				result_q.result_value  <= tag_s2.err ? '0 : sum;
				result_q.result_row    <= tag_s2.row;
				result_q.result_column <= tag_s2.col;
				result_q.is_last       <= tag_s2.last;
				result_q.status        <= tag_s2.err;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign stat.strobe  = result_valid_q;
	assign stat.done    = result_valid_q && result_q.is_last;

	a_refusal_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |-> result.is_last && result.result_value == '0)
		else $error("refusal result malformed");

endmodule
